@@ rtl/multilevel_priority_fifo_defines.svh @@
// ----------------------------------------------------------------------------
// Multilevel priority FIFO assertion macros
// Concurrent check macros used by the core RTL file. With SYNTH defined they
// expand to nothing.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_FIFO_DEFINES_SVH
`define MULTILEVEL_PRIORITY_FIFO_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define MPF_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define MPF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define MPF_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define MPF_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/mpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Multilevel priority FIFO package
// Operation and status codes, the step and result structs and the
// lowest-index encoder shared by the queue files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

	localparam int LEVEL_W    = 4;
	localparam int STATUS_W   = 2;
	localparam int MAX_LEVELS = 16;
	localparam int IDX_W      = 4;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 2'd3;

	typedef struct packed {
		logic               fire;
		logic               opcode;
		logic [LEVEL_W-1:0] level;
	} step_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEVEL_W-1:0]  out_level;
		logic [LEVEL_W-1:0]  head_level;
		logic                is_empty;
	} res_t;

	// Index of the lowest set bit, zero when no bit is set.
	function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_LEVELS-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

@@ rtl/mpf_if.sv @@
// ----------------------------------------------------------------------------
// Multilevel priority FIFO channel interfaces
// Valid/ready channels for the command stream and the response stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpf_cmd_if #(
	parameter int TAG_W = 16
);
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [mpf_pkg::LEVEL_W-1:0]  level;
	logic [TAG_W-1:0]             item_tag;

	modport source (output valid, output opcode, output level, output item_tag, input ready);
	modport sink   (input valid, input opcode, input level, input item_tag, output ready);
endinterface

interface mpf_rsp_if #(
	parameter int TAG_W = 16,
	parameter int OCC_W = 7
);
	logic                         valid;
	logic                         ready;
	logic [mpf_pkg::STATUS_W-1:0] status;
	logic [TAG_W-1:0]             out_tag;
	logic [mpf_pkg::LEVEL_W-1:0]  out_level;
	logic [TAG_W-1:0]             head_tag;
	logic [mpf_pkg::LEVEL_W-1:0]  head_level;
	logic                         is_empty;
	logic [OCC_W-1:0]             occupancy;

	modport source (
		output valid, output status, output out_tag, output out_level,
		output head_tag, output head_level, output is_empty, output occupancy,
		input ready
	);
	modport sink (
		input valid, input status, input out_tag, input out_level,
		input head_tag, input head_level, input is_empty, input occupancy,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/mpf_tag_ram.sv @@
// ----------------------------------------------------------------------------
// Multilevel priority FIFO tag RAM
// One write port and one registered read port, with the write data forwarded
// when both ports hit the same address in a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpf_tag_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/mpf_core.sv @@
// ----------------------------------------------------------------------------
// Multilevel priority FIFO core
// Per-level ring pointers, counts and head tags, the front-level encoder and
// the tag RAM that holds every queued tag, with a prefetch of the entry
// behind the front head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multilevel_priority_fifo_defines.svh"

module mpf_core #(
	parameter int LEVELS    = 9,
	parameter int CAPACITY  = 64,
	parameter int TAG_WIDTH = 16,
	parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mpf_pkg::step_t       step,
	input  wire logic [TAG_WIDTH-1:0] step_tag,
	output mpf_pkg::res_t             res,
	output logic      [TAG_WIDTH-1:0] res_out_tag,
	output logic      [TAG_WIDTH-1:0] res_head_tag,
	output logic      [CNT_W-1:0]     res_occupancy
);

	localparam int LVL_W  = $clog2(LEVELS);
	localparam int PTR_W  = $clog2(CAPACITY);
	localparam int ADDR_W = LVL_W + PTR_W;
	localparam int MAXL   = mpf_pkg::MAX_LEVELS;
	localparam int IDXW   = mpf_pkg::IDX_W;
	localparam int LW     = mpf_pkg::LEVEL_W;

	logic [CNT_W-1:0]     cnt_q  [LEVELS];
	logic [CNT_W-1:0]     cnt_nx [LEVELS];
	logic [PTR_W-1:0]     rd_q   [LEVELS];
	logic [PTR_W-1:0]     rd_nx  [LEVELS];
	logic [PTR_W-1:0]     wr_q   [LEVELS];
	logic [PTR_W-1:0]     wr_nx  [LEVELS];
	logic [TAG_WIDTH-1:0] head_q [LEVELS];
	logic [TAG_WIDTH-1:0] head_nx[LEVELS];
	logic [TAG_WIDTH-1:0] front_tag_q;
	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     total_nx;

	logic [MAXL-1:0]  ne_cur;
	logic [MAXL-1:0]  ne_new;
	logic [IDXW-1:0]  fcur_idx;
	logic [IDXW-1:0]  fnew_idx;
	logic [LVL_W-1:0] f_cur;
	logic [LVL_W-1:0] f_new;
	logic             any_q;
	logic             any_nx;

	logic [LW-1:0]    lvl_m1;
	logic [LVL_W-1:0] lidx;
	logic             lvl_ok;
	logic             full;
	logic             enq_ok;
	logic             deq_ok;
	logic             enq_hit;
	logic             deq_hit;

	logic [TAG_WIDTH-1:0] head_sel;
	logic [TAG_WIDTH-1:0] pf_tag;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;

	always_comb begin
		ne_cur = '0;
		for (int l = 0; l < LEVELS; l++) begin
			ne_cur[l] = (cnt_q[l] != '0);
		end
	end

	assign fcur_idx = mpf_pkg::lowest_set(ne_cur);
	assign f_cur    = fcur_idx[LVL_W-1:0];
	assign any_q    = |ne_cur;

	assign lvl_m1 = step.level - LW'(1);
	assign lidx   = lvl_m1[LVL_W-1:0];
	assign lvl_ok = (step.level != '0) && (int'(step.level) <= LEVELS);
	assign full   = (total_q == CNT_W'(CAPACITY));
	assign enq_ok = step.fire && (step.opcode == mpf_pkg::OP_ENQ) && lvl_ok && !full;
	assign deq_ok = step.fire && (step.opcode == mpf_pkg::OP_DEQ) && any_q;

	always_comb begin
		ne_new  = '0;
		enq_hit = 1'b0;
		deq_hit = 1'b0;
		for (int l = 0; l < LEVELS; l++) begin
			enq_hit    = enq_ok && (lidx == LVL_W'(l));
			deq_hit    = deq_ok && (f_cur == LVL_W'(l));
			cnt_nx[l]  = cnt_q[l];
			rd_nx[l]   = rd_q[l];
			wr_nx[l]   = wr_q[l];
			head_nx[l] = head_q[l];
			if (enq_hit) begin
				cnt_nx[l] = cnt_q[l] + CNT_W'(1);
				wr_nx[l]  = wr_q[l] + PTR_W'(1);
				if (cnt_q[l] == '0) begin
					head_nx[l] = step_tag;
				end
			end
			if (deq_hit) begin
				cnt_nx[l]  = cnt_q[l] - CNT_W'(1);
				rd_nx[l]   = rd_q[l] + PTR_W'(1);
				head_nx[l] = pf_tag;
			end
			ne_new[l] = (cnt_nx[l] != '0);
		end
	end

	assign fnew_idx = mpf_pkg::lowest_set(ne_new);
	assign f_new    = fnew_idx[LVL_W-1:0];
	assign any_nx   = |ne_new;
	assign head_sel = head_nx[f_new];

	always_comb begin
		total_nx = total_q;
		if (enq_ok) begin
			total_nx = total_q + CNT_W'(1);
		end else if (deq_ok) begin
			total_nx = total_q - CNT_W'(1);
		end
	end

	assign waddr = {lidx, wr_q[lidx]};
	assign raddr = {f_new, rd_nx[f_new] + PTR_W'(1)};

	mpf_tag_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (TAG_WIDTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (enq_ok),
		.waddr (waddr),
		.wdata (step_tag),
		.raddr (raddr),
		.rdata (pf_tag)
	);

	always_comb begin
		res.status = mpf_pkg::ST_OK;
		if (step.opcode == mpf_pkg::OP_ENQ) begin
			if (!lvl_ok) begin
				res.status = mpf_pkg::ST_BAD_LEVEL;
			end else if (full) begin
				res.status = mpf_pkg::ST_FULL;
			end
		end else if (!any_q) begin
			res.status = mpf_pkg::ST_EMPTY;
		end
		res.out_level  = deq_ok ? (fcur_idx + LW'(1)) : '0;
		res.head_level = any_nx ? (fnew_idx + LW'(1)) : '0;
		res.is_empty   = (total_nx == '0);
	end

	assign res_out_tag   = deq_ok ? front_tag_q : '0;
	assign res_head_tag  = any_nx ? head_sel : '0;
	assign res_occupancy = total_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				cnt_q[l] <= '0;
				rd_q[l]  <= '0;
				wr_q[l]  <= '0;
			end
		end else begin
			total_q <= total_nx;
			for (int l = 0; l < LEVELS; l++) begin
				cnt_q[l] <= cnt_nx[l];
				rd_q[l]  <= rd_nx[l];
				wr_q[l]  <= wr_nx[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		front_tag_q <= head_sel;
		for (int l = 0; l < LEVELS; l++) begin
			head_q[l] <= head_nx[l];
		end
	end

	`MPF_ASSERT_SAME(a_occ_bound, clk, arst_n, 1'b1, total_q <= CNT_W'(CAPACITY))
	`MPF_ASSERT_SAME(a_empty_map, clk, arst_n, 1'b1, (total_q == '0) == !any_q)
	`MPF_ASSERT_NEXT(a_deq_dec, clk, arst_n, deq_ok, total_q == $past(total_q) - CNT_W'(1))
	`MPF_ASSERT_NEXT(a_reject_hold, clk, arst_n, step.fire && (res.status != mpf_pkg::ST_OK), total_q == $past(total_q))

endmodule

`default_nettype wire

@@ rtl/multilevel_priority_fifo.sv @@
// ----------------------------------------------------------------------------
// Multilevel priority FIFO
// Strict priority queue with one FIFO per level over a shared item budget.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on cmd: opcode selects an enqueue of item_tag at level, or
// a dequeue of the front item. Level 1 is served first and items of one level
// leave in arrival order. Every command produces one transaction on rsp with
// a status, the dequeued tag and level, the new front tag and level, an empty
// flag and the occupancy.
// A command is captured in an input register and processed when it moves
// into the response register. One command per cycle is sustained while rsp
// is not stalled; the level pointers are updated and the tag RAM written as
// each command is processed, with the RAM read port prefetching the entry
// behind the front head.
// Reset clears the counts and pointers at once; the queue is empty and ready
// as soon as reset is released, with no clearing pass.
// When rsp is stalled the response is held, one more command may wait in the
// input register, and cmd.ready then drops until the response is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multilevel_priority_fifo #(
	parameter int LEVELS    = 9,
	parameter int CAPACITY  = 64,
	parameter int TAG_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	mpf_cmd_if.sink   cmd,
	mpf_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LW    = mpf_pkg::LEVEL_W;

	logic                 valid_s1;
	logic                 opcode_s1;
	logic [LW-1:0]        level_s1;
	logic [TAG_WIDTH-1:0] tag_s1;

	logic                 valid_s2;
	mpf_pkg::res_t        res_s2;
	logic [TAG_WIDTH-1:0] out_tag_s2;
	logic [TAG_WIDTH-1:0] head_tag_s2;
	logic [CNT_W-1:0]     occ_s2;

	logic                 fire;
	logic                 take;
	mpf_pkg::step_t       step;
	mpf_pkg::res_t        res;
	logic [TAG_WIDTH-1:0] res_out_tag;
	logic [TAG_WIDTH-1:0] res_head_tag;
	logic [CNT_W-1:0]     res_occupancy;

	assign fire      = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || fire;
	assign take      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !fire);
			valid_s2 <= fire || (valid_s2 && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= cmd.opcode;
			level_s1  <= cmd.level;
			tag_s1    <= cmd.item_tag;
		end
		if (fire) begin
			res_s2      <= res;
			out_tag_s2  <= res_out_tag;
			head_tag_s2 <= res_head_tag;
			occ_s2      <= res_occupancy;
		end
	end

	assign step.fire   = fire;
	assign step.opcode = opcode_s1;
	assign step.level  = level_s1;

	mpf_core #(
		.LEVELS    (LEVELS),
		.CAPACITY  (CAPACITY),
		.TAG_WIDTH (TAG_WIDTH),
		.CNT_W     (CNT_W)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.step_tag      (tag_s1),
		.res           (res),
		.res_out_tag   (res_out_tag),
		.res_head_tag  (res_head_tag),
		.res_occupancy (res_occupancy)
	);

	assign rsp.valid      = valid_s2;
	assign rsp.status     = res_s2.status;
	assign rsp.out_tag    = out_tag_s2;
	assign rsp.out_level  = res_s2.out_level;
	assign rsp.head_tag   = head_tag_s2;
	assign rsp.head_level = res_s2.head_level;
	assign rsp.is_empty   = res_s2.is_empty;
	assign rsp.occupancy  = occ_s2;

endmodule

`default_nettype wire

@@ tb/mpf_checker.sv @@
// ----------------------------------------------------------------------------
// Multilevel priority FIFO response checker
// Watches the command and response channels, keeps a per-level FIFO image
// of the queue, works out the response due for every accepted command and
// compares each accepted response with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpf_checker #(
	parameter int LEVELS   = 9,
	parameter int CAPACITY = 64,
	parameter int TAG_W    = 16,
	parameter int OCC_W    = 7
) (
	input  logic clk,
	input  logic arst_n,
	mpf_cmd_if   cmd,
	mpf_rsp_if   rsp,
	output int   fail_cnt,
	output int   pending_cnt,
	output int   checked_cnt,
	output int   ok_cnt,
	output int   full_cnt,
	output int   empty_cnt,
	output int   bad_level_cnt
);

	typedef struct packed {
		logic [mpf_pkg::STATUS_W-1:0] status;
		logic [TAG_W-1:0]             out_tag;
		logic [mpf_pkg::LEVEL_W-1:0]  out_level;
		logic [TAG_W-1:0]             head_tag;
		logic [mpf_pkg::LEVEL_W-1:0]  head_level;
		logic                         is_empty;
		logic [OCC_W-1:0]             occupancy;
	} rsp_fields_t;

	logic [TAG_W-1:0] level_tags [LEVELS][CAPACITY];
	int               level_rd   [LEVELS];
	int               level_cnt  [LEVELS];
	int               held_total;

	rsp_fields_t expected_rsp_q [$];
	rsp_fields_t got_rsp;
	rsp_fields_t due_rsp;
	int          errors;
	int          n_checked;
	int          n_status [4];

	function automatic int front_level();
		int f;
		f = LEVELS;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (level_cnt[i] != 0) begin
				f = i;
			end
		end
		return f;
	endfunction

	function automatic rsp_fields_t queue_step(input logic op,
			input logic [mpf_pkg::LEVEL_W-1:0] lvl, input logic [TAG_W-1:0] tag);
		rsp_fields_t r;
		int          idx;
		int          f;
		r = '0;
		r.status = mpf_pkg::ST_OK;
		if (op == mpf_pkg::OP_ENQ) begin
			if (lvl < 1 || lvl > LEVELS) begin
				r.status = mpf_pkg::ST_BAD_LEVEL;
			end else if (held_total >= CAPACITY) begin
				r.status = mpf_pkg::ST_FULL;
			end else begin
				idx = int'(lvl) - 1;
				level_tags[idx][(level_rd[idx] + level_cnt[idx]) % CAPACITY] = tag;
				level_cnt[idx]++;
				held_total++;
			end
		end else begin
			f = front_level();
			if (f >= LEVELS) begin
				r.status = mpf_pkg::ST_EMPTY;
			end else begin
				r.out_tag   = level_tags[f][level_rd[f]];
				r.out_level = mpf_pkg::LEVEL_W'(f + 1);
				level_rd[f] = (level_rd[f] + 1) % CAPACITY;
				level_cnt[f]--;
				held_total--;
			end
		end
		f = front_level();
		if (f < LEVELS) begin
			r.head_tag   = level_tags[f][level_rd[f]];
			r.head_level = mpf_pkg::LEVEL_W'(f + 1);
		end
		r.is_empty  = (held_total == 0);
		r.occupancy = OCC_W'(held_total);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				level_rd[i]  = 0;
				level_cnt[i] = 0;
			end
			for (int i = 0; i < 4; i++) begin
				n_status[i] = 0;
			end
			held_total = 0;
			errors     = 0;
			n_checked  = 0;
			expected_rsp_q.delete();
			fail_cnt      <= 0;
			pending_cnt   <= 0;
			checked_cnt   <= 0;
			ok_cnt        <= 0;
			full_cnt      <= 0;
			empty_cnt     <= 0;
			bad_level_cnt <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got_rsp.status     = rsp.status;
				got_rsp.out_tag    = rsp.out_tag;
				got_rsp.out_level  = rsp.out_level;
				got_rsp.head_tag   = rsp.head_tag;
				got_rsp.head_level = rsp.head_level;
				got_rsp.is_empty   = rsp.is_empty;
				got_rsp.occupancy  = rsp.occupancy;
				if (expected_rsp_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("[%0t] ERROR: response transaction with none due: status=%0d",
							$realtime, got_rsp.status);
					end
				end else begin
					due_rsp = expected_rsp_q.pop_front();
					n_checked++;
					n_status[due_rsp.status]++;
					if (got_rsp.status !== due_rsp.status
							|| got_rsp.out_tag !== due_rsp.out_tag
							|| got_rsp.out_level !== due_rsp.out_level
							|| got_rsp.head_tag !== due_rsp.head_tag
							|| got_rsp.head_level !== due_rsp.head_level
							|| got_rsp.is_empty !== due_rsp.is_empty
							|| got_rsp.occupancy !== due_rsp.occupancy) begin
						errors++;
						if (errors <= 10) begin
							$display("[%0t] ERROR: response %0d mismatch", $realtime, n_checked);
							$display("  exp status=%0d out=%h/%0d head=%h/%0d empty=%0d occ=%0d",
								due_rsp.status, due_rsp.out_tag, due_rsp.out_level,
								due_rsp.head_tag, due_rsp.head_level, due_rsp.is_empty,
								due_rsp.occupancy);
							$display("  got status=%0d out=%h/%0d head=%h/%0d empty=%0d occ=%0d",
								got_rsp.status, got_rsp.out_tag, got_rsp.out_level,
								got_rsp.head_tag, got_rsp.head_level, got_rsp.is_empty,
								got_rsp.occupancy);
						end
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				expected_rsp_q.push_back(queue_step(cmd.opcode, cmd.level, cmd.item_tag));
			end
			fail_cnt      <= errors;
			pending_cnt   <= expected_rsp_q.size();
			checked_cnt   <= n_checked;
			ok_cnt        <= n_status[mpf_pkg::ST_OK];
			full_cnt      <= n_status[mpf_pkg::ST_FULL];
			empty_cnt     <= n_status[mpf_pkg::ST_EMPTY];
			bad_level_cnt <= n_status[mpf_pkg::ST_BAD_LEVEL];
		end
	end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Multilevel priority FIFO testbench
// Drives directed and random enqueue and dequeue commands with random gaps
// on the command side and random stalls on the response side. The checker
// beside the block predicts and compares every response transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int LEVELS       = 9;
	localparam int CAPACITY     = 64;
	localparam int TAG_W        = 16;
	localparam int OCC_W        = 7;
	localparam int RANDOM_ITEMS = 1250;
	localparam int LEVEL_W      = mpf_pkg::LEVEL_W;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED,
		MODE_LIGHT
	} traffic_mode_t;

	logic clk;
	logic arst_n;

	int fail_cnt;
	int pending_cnt;
	int checked_cnt;
	int ok_cnt;
	int full_cnt;
	int empty_cnt;
	int bad_level_cnt;

	int n_sent;
	int n_directed;
	int n_random;
	int n_episodes;

	mpf_cmd_if #(.TAG_W(TAG_W)) cmd_ch ();
	mpf_rsp_if #(.TAG_W(TAG_W), .OCC_W(OCC_W)) rsp_ch ();

	multilevel_priority_fifo #(
		.LEVELS   (LEVELS),
		.CAPACITY (CAPACITY),
		.TAG_WIDTH(TAG_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	mpf_checker #(
		.LEVELS  (LEVELS),
		.CAPACITY(CAPACITY),
		.TAG_W   (TAG_W),
		.OCC_W   (OCC_W)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.rsp          (rsp_ch),
		.fail_cnt     (fail_cnt),
		.pending_cnt  (pending_cnt),
		.checked_cnt  (checked_cnt),
		.ok_cnt       (ok_cnt),
		.full_cnt     (full_cnt),
		.empty_cnt    (empty_cnt),
		.bad_level_cnt(bad_level_cnt)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic send_cmd(input logic op, input logic [LEVEL_W-1:0] lvl,
			input logic [TAG_W-1:0] tag);
		cmd_ch.valid    <= 1'b1;
		cmd_ch.opcode   <= op;
		cmd_ch.level    <= lvl;
		cmd_ch.item_tag <= tag;
		do begin
			@(posedge clk);
		end while (cmd_ch.ready !== 1'b1);
		n_sent++;
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_all_responses();
		cmd_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_cnt != 0);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		int r;
		r = $urandom_range(0, 99);
		if (r < 90) begin
			return LEVEL_W'($urandom_range(1, LEVELS));
		end else if (r < 93) begin
			return '0;
		end
		return LEVEL_W'($urandom_range(LEVELS + 1, 15));
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end
		return TAG_W'($urandom);
	endfunction

	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int hold;
			int r;
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					rsp_ch.ready <= 1'b1;
					hold = $urandom_range(0, 5);
				end else if (r < 95) begin
					rsp_ch.ready <= 1'b0;
					hold = $urandom_range(0, 3);
				end else if (r < 98) begin
					rsp_ch.ready <= 1'b0;
					hold = $urandom_range(10, 40);
				end else begin
					rsp_ch.ready <= 1'b1;
					hold = $urandom_range(50, 150);
				end
			end
		end
	end

	initial begin
		traffic_mode_t mode;
		int            ep_len;
		int            enq_pct;
		bit            no_gaps;

		n_sent     = 0;
		n_directed = 0;
		n_random   = 0;
		n_episodes = 0;

		arst_n          <= 1'b0;
		cmd_ch.valid    <= 1'b0;
		cmd_ch.opcode   <= mpf_pkg::OP_ENQ;
		cmd_ch.level    <= '0;
		cmd_ch.item_tag <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty dequeue, bad levels on an empty queue, then interleaved levels.
		send_cmd(mpf_pkg::OP_DEQ, 4'd5, 16'hFFFF);
		send_cmd(mpf_pkg::OP_ENQ, 4'd0, 16'hFFFF);
		send_cmd(mpf_pkg::OP_ENQ, 4'd10, 16'h1111);
		send_cmd(mpf_pkg::OP_ENQ, 4'd15, 16'h2222);
		send_cmd(mpf_pkg::OP_ENQ, 4'd9, 16'hFFFF);
		send_cmd(mpf_pkg::OP_ENQ, 4'd1, 16'h0000);
		send_cmd(mpf_pkg::OP_ENQ, 4'd5, 16'hA5A5);
		send_cmd(mpf_pkg::OP_ENQ, 4'd1, 16'h5A5A);
		idle_cycles(3);
		send_cmd(mpf_pkg::OP_ENQ, 4'd9, 16'h1234);
		send_cmd(mpf_pkg::OP_DEQ, 4'd15, 16'hFFFF);
		send_cmd(mpf_pkg::OP_DEQ, 4'd0, 16'h0000);
		send_cmd(mpf_pkg::OP_ENQ, 4'd2, 16'h8001);
		send_cmd(mpf_pkg::OP_DEQ, 4'd8, 16'h7FFE);
		send_cmd(mpf_pkg::OP_DEQ, 4'd3, 16'hC3C3);
		send_cmd(mpf_pkg::OP_ENQ, 4'd0, 16'h0001);
		send_cmd(mpf_pkg::OP_DEQ, 4'd1, 16'h0000);
		send_cmd(mpf_pkg::OP_DEQ, 4'd9, 16'hFFFF);
		send_cmd(mpf_pkg::OP_DEQ, 4'd9, 16'hFFFF);
		send_cmd(mpf_pkg::OP_ENQ, 4'd8, 16'h8000);
		send_cmd(mpf_pkg::OP_DEQ, 4'd7, 16'h0F0F);
		n_directed = n_sent;
		wait_all_responses();

		// Random traffic in episodes; the first one fills the store past full.
		while (n_random < RANDOM_ITEMS) begin
			if (n_episodes == 0) begin
				mode = MODE_FILL;
			end else begin
				mode = traffic_mode_t'($urandom_range(0, 3));
			end
			case (mode)
				MODE_FILL: begin
					enq_pct = 92;
					ep_len  = $urandom_range(100, 160);
				end
				MODE_DRAIN: begin
					enq_pct = 10;
					ep_len  = $urandom_range(60, 120);
				end
				MODE_MIXED: begin
					enq_pct = 50;
					ep_len  = $urandom_range(40, 120);
				end
				default: begin
					enq_pct = 35;
					ep_len  = $urandom_range(20, 60);
				end
			endcase
			no_gaps = ($urandom_range(0, 3) == 0);
			n_episodes++;
			for (int i = 0; i < ep_len && n_random < RANDOM_ITEMS; i++) begin
				if ($urandom_range(0, 99) < enq_pct) begin
					send_cmd(mpf_pkg::OP_ENQ, pick_level(), pick_tag());
				end else begin
					send_cmd(mpf_pkg::OP_DEQ, LEVEL_W'($urandom), TAG_W'($urandom));
				end
				n_random++;
				if (!no_gaps) begin
					idle_cycles(pick_gap());
				end
			end
			if ($urandom_range(0, 9) < 3) begin
				wait_all_responses();
			end
		end

		wait_all_responses();
		repeat (20) @(posedge clk);

		$display("Sent %0d commands (%0d directed, %0d random in %0d episodes), %0d checked.",
			n_sent, n_directed, n_random, n_episodes, checked_cnt);
		$display("Responses by status: ok %0d, full %0d, empty %0d, bad level %0d.",
			ok_cnt, full_cnt, empty_cnt, bad_level_cnt);
		if (fail_cnt == 0 && pending_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
